[hdl/dtsf_pkg.sv]
// shared types and constants of the detection target selector framer
package dtsf_pkg;

  localparam int COORD_BITS  = 13;
  localparam int CENTER_BITS = 14;
  localparam int CONF_BITS   = 16;
  localparam int CX_BITS     = COORD_BITS + 2;
  localparam int DIFF_BITS   = (CX_BITS > CENTER_BITS) ? CX_BITS : CENTER_BITS;
  localparam int SQ_BITS     = 2 * DIFF_BITS;
  localparam int DIST_BITS   = SQ_BITS + 1;
  localparam int PIX_BITS    = 16;
  localparam int FRAME_LEN   = 8;
  localparam int BEAT_BITS   = $clog2(FRAME_LEN);

  localparam int FRAME_QUEUE_DEPTH = 4;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;

  localparam logic [PIX_BITS-1:0] PIX_MAX = '1;

  localparam logic [7:0] SYNC_HEAD_0 = 8'hFA;
  localparam logic [7:0] SYNC_HEAD_1 = 8'hFB;
  localparam logic [7:0] SYNC_TAIL_0 = 8'hFC;
  localparam logic [7:0] SYNC_TAIL_1 = 8'hFD;

  localparam logic [CENTER_BITS-1:0] CENTER_X_RESET = 14'd1280;
  localparam logic [CENTER_BITS-1:0] CENTER_Y_RESET = 14'd1024;
  localparam logic [CONF_BITS-1:0]   MIN_CONF_RESET = 16'd32768;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_MIN_CONF = 2'd2,
    REG_SELECT   = 2'd3
  } reg_idx_e;

  typedef enum logic [BEAT_BITS-1:0] {
    BEAT_HEAD_0 = 3'd0,
    BEAT_HEAD_1 = 3'd1,
    BEAT_X_LO   = 3'd2,
    BEAT_X_HI   = 3'd3,
    BEAT_Y_LO   = 3'd4,
    BEAT_Y_HI   = 3'd5,
    BEAT_TAIL_0 = 3'd6,
    BEAT_TAIL_1 = 3'd7
  } beat_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_x_offset;
    logic [COORD_BITS-1:0] box_y_offset;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic [CONF_BITS-1:0]  confidence;
    logic                  class_match;
    logic                  has_box;
    logic                  last_in_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [CENTER_BITS-1:0] center_x_half;
    logic [CENTER_BITS-1:0] center_y_half;
    logic [CONF_BITS-1:0]   conf_floor;
    logic                   select_by_confidence;
  } cfg_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] x_pix;
    logic [PIX_BITS-1:0] y_pix;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/dtsf_front.sv]
// front end: qualifies boxes, computes center distance, keeps the best box per message
module dtsf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtsf_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dtsf_pkg::in_item_t  in_data_i,
  input  dtsf_pkg::q_stat_t   q_stat_i,
  output logic                push_o,
  output dtsf_pkg::frame_rec_t push_rec_o
);

  localparam int CXB  = dtsf_pkg::CX_BITS;
  localparam int DB   = dtsf_pkg::DIFF_BITS;
  localparam int SQB  = dtsf_pkg::SQ_BITS;
  localparam int DSTB = dtsf_pkg::DIST_BITS;
  localparam int CFB  = dtsf_pkg::CONF_BITS;
  localparam int PXB  = dtsf_pkg::PIX_BITS;
  localparam int SATB = CXB + PXB;

  typedef struct packed {
    logic           last;
    logic           qual;
    logic [CFB-1:0] conf;
    logic [CXB-1:0] cx;
    logic [CXB-1:0] cy;
    logic [DB-1:0]  dx;
    logic [DB-1:0]  dy;
  } s1_t;

  typedef struct packed {
    logic           last;
    logic           qual;
    logic [CFB-1:0] conf;
    logic [CXB-1:0] cx;
    logic [CXB-1:0] cy;
    logic [SQB-1:0] dx2;
    logic [SQB-1:0] dy2;
  } s2_t;

  logic            s1_valid_q, s1_valid_d;
  s1_t             s1_q, s1_d;
  logic            s2_valid_q;
  s2_t             s2_q, s2_d;

  logic            best_valid_q;
  logic [CXB-1:0]  best_cx_q, best_cy_q;
  logic [DSTB-1:0] best_dist_q;
  logic [CFB-1:0]  best_conf_q;

  logic            advance;
  logic [DSTB-1:0] dist_sum;
  logic            take;
  logic            nb_valid;
  logic [CXB-1:0]  nb_cx, nb_cy;
  logic [CXB-1:0]  rx, ry;
  logic [CXB:0]    rx_full, ry_full;

  // the whole pipe waits only when the last box of a message is in the final stage and the queue is full
  assign advance    = !(s2_valid_q && s2_q.last && q_stat_i.full);
  assign in_stall_o = !advance;

  always_comb begin
    logic [CXB-1:0] cx, cy;
    logic [DB-1:0]  ax, ay, bx, by;
    cx = {1'b0, in_data_i.box_x_offset, 1'b0} + CXB'(in_data_i.box_width);
    cy = {1'b0, in_data_i.box_y_offset, 1'b0} + CXB'(in_data_i.box_height);
    ax = DB'(cx);
    ay = DB'(cy);
    bx = DB'(cfg_i.center_x_half);
    by = DB'(cfg_i.center_y_half);
    s1_valid_d = in_valid_i;
    s1_d.last  = in_data_i.last_in_message;
    s1_d.qual  = in_data_i.class_match && in_data_i.has_box &&
                 (in_data_i.confidence >= cfg_i.conf_floor);
    s1_d.conf  = in_data_i.confidence;
    s1_d.cx    = cx;
    s1_d.cy    = cy;
    s1_d.dx    = (ax >= bx) ? (ax - bx) : (bx - ax);
    s1_d.dy    = (ay >= by) ? (ay - by) : (by - ay);
  end

  always_comb begin
    s2_d.last = s1_q.last;
    s2_d.qual = s1_q.qual;
    s2_d.conf = s1_q.conf;
    s2_d.cx   = s1_q.cx;
    s2_d.cy   = s1_q.cy;
    s2_d.dx2  = SQB'(s1_q.dx) * SQB'(s1_q.dx);
    s2_d.dy2  = SQB'(s1_q.dy) * SQB'(s1_q.dy);
  end

  always_comb begin
    dist_sum = DSTB'(s2_q.dx2) + DSTB'(s2_q.dy2);
    take = s2_valid_q && s2_q.qual &&
           (!best_valid_q ||
            (cfg_i.select_by_confidence ? (s2_q.conf > best_conf_q)
                                        : (dist_sum < best_dist_q)));
    nb_valid = best_valid_q || take;
    nb_cx    = take ? s2_q.cx : best_cx_q;
    nb_cy    = take ? s2_q.cy : best_cy_q;
    // round half away from zero, then saturate to the frame field
    rx_full  = (CXB + 1)'(nb_cx) + (CXB + 1)'(1);
    ry_full  = (CXB + 1)'(nb_cy) + (CXB + 1)'(1);
    rx       = rx_full[CXB:1];
    ry       = ry_full[CXB:1];
    push_rec_o.x_pix = (SATB'(rx) > SATB'(dtsf_pkg::PIX_MAX)) ? dtsf_pkg::PIX_MAX : PXB'(rx);
    push_rec_o.y_pix = (SATB'(ry) > SATB'(dtsf_pkg::PIX_MAX)) ? dtsf_pkg::PIX_MAX : PXB'(ry);
    push_o   = advance && s2_valid_q && s2_q.last && nb_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      best_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q) begin
        best_valid_q <= s2_q.last ? 1'b0 : nb_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      if (take) begin
        best_cx_q   <= s2_q.cx;
        best_cy_q   <= s2_q.cy;
        best_dist_q <= dist_sum;
        best_conf_q <= s2_q.conf;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s2_valid_q && s2_q.last |=> !best_valid_q)
    else $error("kept box survived the end of its message");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_stat_i.full)
    else $error("frame pushed into a full queue");

  a_stall_holds_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> s2_valid_q && s2_q.last && $stable(best_valid_q))
    else $error("final stage moved while stalled");

endmodule

[hdl/dtsf_fifo.sv]
// short frame record queue between front and back
module dtsf_fifo #(
  parameter int DEPTH = dtsf_pkg::FRAME_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dtsf_pkg::frame_rec_t push_rec_i,
  input  logic                 pop_i,
  output dtsf_pkg::frame_rec_t pop_rec_o,
  output dtsf_pkg::q_stat_t    stat_o
);

  localparam int AW = $clog2(DEPTH);

  dtsf_pkg::frame_rec_t mem_q [DEPTH];
  logic [AW:0] wr_ptr_q, rd_ptr_q;

  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.full  = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) &&
                        (wr_ptr_q[AW] != rd_ptr_q[AW]);
  assign pop_rec_o    = mem_q[rd_ptr_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + (AW + 1)'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[AW-1:0]] <= push_rec_i;
    end
  end

endmodule

[hdl/dtsf_back.sv]
// back end: serializes one queued position record into an 8-byte frame
module dtsf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtsf_pkg::q_stat_t    q_stat_i,
  input  dtsf_pkg::frame_rec_t pop_rec_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dtsf_pkg::out_item_t  out_data_o
);

  logic                  busy_q;
  dtsf_pkg::beat_e       beat_q;
  dtsf_pkg::frame_rec_t  rec_q;
  logic                  beat_done;
  logic                  frame_done;

  assign beat_done  = busy_q && !out_stall_i;
  assign frame_done = beat_done && (beat_q == dtsf_pkg::BEAT_TAIL_1);
  assign pop_o      = !q_stat_i.empty && (!busy_q || frame_done);

  assign out_valid_o          = busy_q;
  assign out_data_o.frame_end = (beat_q == dtsf_pkg::BEAT_TAIL_1);

  always_comb begin
    case (beat_q)
      dtsf_pkg::BEAT_HEAD_0: out_data_o.frame_byte = dtsf_pkg::SYNC_HEAD_0;
      dtsf_pkg::BEAT_HEAD_1: out_data_o.frame_byte = dtsf_pkg::SYNC_HEAD_1;
      dtsf_pkg::BEAT_X_LO:   out_data_o.frame_byte = rec_q.x_pix[7:0];
      dtsf_pkg::BEAT_X_HI:   out_data_o.frame_byte = rec_q.x_pix[15:8];
      dtsf_pkg::BEAT_Y_LO:   out_data_o.frame_byte = rec_q.y_pix[7:0];
      dtsf_pkg::BEAT_Y_HI:   out_data_o.frame_byte = rec_q.y_pix[15:8];
      dtsf_pkg::BEAT_TAIL_0: out_data_o.frame_byte = dtsf_pkg::SYNC_TAIL_0;
      dtsf_pkg::BEAT_TAIL_1: out_data_o.frame_byte = dtsf_pkg::SYNC_TAIL_1;
      default:               out_data_o.frame_byte = dtsf_pkg::SYNC_HEAD_0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= dtsf_pkg::BEAT_HEAD_0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      beat_q <= dtsf_pkg::BEAT_HEAD_0;
    end else if (frame_done) begin
      busy_q <= 1'b0;
      beat_q <= dtsf_pkg::BEAT_HEAD_0;
    end else if (beat_done) begin
      beat_q <= dtsf_pkg::beat_e'(beat_q + dtsf_pkg::BEAT_BITS'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= pop_rec_i;
    end
  end

  a_pop_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy_q || frame_done)
    else $error("record popped in the middle of a frame");

  a_frame_starts_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> !busy_q || beat_q == dtsf_pkg::BEAT_HEAD_0)
    else $error("next frame did not start with its first beat");

  a_no_beat_skipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_stall_i |=> busy_q && $stable(beat_q))
    else $error("beat advanced while stalled");

endmodule

[hdl/detection_target_selector_framer.sv]
// top level: config registers, front selector, frame queue and byte serializer
//
//  channel   direction  handshake                     payload
//  in        input      in_valid_i / in_stall_o       in_data_i (one detection box)
//  out       output     out_valid_o / out_stall_i     out_data_o (one frame byte)
//  cfg       input      psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// one box is taken every cycle while in_stall_o is low; a three-stage pipe (center
// and difference, squares, sum/compare/keep) selects, and the last box of a message
// pushes the kept box as a frame record. the serializer sends 8 beats per frame, one
// per cycle while out_stall_i is low; the queue holds FRAME_QUEUE_DEPTH frames, and
// input stalls only when a message ends with it full.
// reset clears the kept box and loads the register defaults, no clearing pass.
module detection_target_selector_framer #(
  parameter int FRAME_QUEUE_DEPTH = dtsf_pkg::FRAME_QUEUE_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  dtsf_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output dtsf_pkg::out_item_t                   out_data_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dtsf_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [dtsf_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [dtsf_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);

  localparam int DW = dtsf_pkg::APB_DATA_BITS;

  dtsf_pkg::cfg_t       cfg_q;
  dtsf_pkg::reg_idx_e   reg_idx;
  logic                 reg_wr;
  logic                 push;
  logic                 pop;
  dtsf_pkg::frame_rec_t push_rec;
  dtsf_pkg::frame_rec_t pop_rec;
  dtsf_pkg::q_stat_t    q_stat;

  assign pready  = 1'b1;
  assign reg_idx = dtsf_pkg::reg_idx_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x_half        <= dtsf_pkg::CENTER_X_RESET;
      cfg_q.center_y_half        <= dtsf_pkg::CENTER_Y_RESET;
      cfg_q.conf_floor           <= dtsf_pkg::MIN_CONF_RESET;
      cfg_q.select_by_confidence <= 1'b0;
    end else if (reg_wr) begin
      case (reg_idx)
        dtsf_pkg::REG_CENTER_X:
          cfg_q.center_x_half <= pwdata[dtsf_pkg::CENTER_BITS-1:0];
        dtsf_pkg::REG_CENTER_Y:
          cfg_q.center_y_half <= pwdata[dtsf_pkg::CENTER_BITS-1:0];
        dtsf_pkg::REG_MIN_CONF:
          cfg_q.conf_floor <= pwdata[dtsf_pkg::CONF_BITS-1:0];
        dtsf_pkg::REG_SELECT:
          cfg_q.select_by_confidence <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dtsf_pkg::REG_CENTER_X: prdata = DW'(cfg_q.center_x_half);
      dtsf_pkg::REG_CENTER_Y: prdata = DW'(cfg_q.center_y_half);
      dtsf_pkg::REG_MIN_CONF: prdata = DW'(cfg_q.conf_floor);
      dtsf_pkg::REG_SELECT:   prdata = DW'(cfg_q.select_by_confidence);
      default:                prdata = '0;
    endcase
  end

  dtsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  dtsf_fifo #(
    .DEPTH (FRAME_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .stat_o     (q_stat)
  );

  dtsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_rec_i   (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
